// ----- sv/ubot_pkg.sv -----
package ubot_pkg;

    localparam int MAX_PACKET_DEF = 64;
    localparam logic [31:0] CBW_SIG = 32'h43425355;
    localparam logic [6:0] CBW_LEN = 7'd31;
    localparam logic [6:0] CSW_LEN = 7'd13;

    localparam logic [2:0] REQ_OUT   = 3'd0;
    localparam logic [2:0] REQ_IN    = 3'd1;
    localparam logic [2:0] REQ_READY = 3'd2;
    localparam logic [2:0] REQ_DONE  = 3'd3;
    localparam logic [2:0] REQ_RESET = 3'd4;

    localparam logic [1:0] M_CBW  = 2'd0;
    localparam logic [1:0] M_DOUT = 2'd1;
    localparam logic [1:0] M_DIN  = 2'd2;
    localparam logic [1:0] M_CSW  = 2'd3;

    localparam logic [2:0] R_NONE  = 3'd0;
    localparam logic [2:0] R_ACC   = 3'd1;
    localparam logic [2:0] R_STALL = 3'd2;
    localparam logic [2:0] R_DEFER = 3'd3;
    localparam logic [2:0] R_DONE  = 3'd4;

    localparam logic [1:0] DREQ_NONE  = 2'd0;
    localparam logic [1:0] DREQ_READ  = 2'd1;
    localparam logic [1:0] DREQ_WRITE = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  endpoint;
        logic [6:0]  pkt_len;
        logic [31:0] cbw_signature;
        logic [31:0] cbw_tag;
        logic [31:0] cbw_transfer_len;
        logic        cbw_dir_in;
        logic [3:0]  cbw_lun;
        logic [31:0] scsi_arg;
    } t_in;

    typedef struct packed {
        logic [2:0]  resp_code;
        logic [6:0]  byte_count;
        logic [6:0]  copy_count;
        logic [6:0]  zero_fill_count;
        logic        csw_valid;
        logic [31:0] csw_tag;
        logic [31:0] csw_residue;
        logic        csw_status;
        logic        cmd_issue;
        logic [1:0]  data_req;
        logic [3:0]  req_lun;
        logic [1:0]  mode_now;
    } t_out;

    // classified event handed from front to back
    typedef struct packed {
        t_in  item;
        logic pkt_ok;   // endpoint and size fit the packet type
        logic cbw_ok;   // length and signature of a CBW
        logic bad_type;
    } t_evt;

endpackage

// ----- sv/ubot_front.sv -----
module ubot_front #(
    parameter int MAX_PACKET = ubot_pkg::MAX_PACKET_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ubot_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ubot_pkg::t_evt  o_evt
);
    // two-entry queue
    ubot_pkg::t_evt r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    ubot_pkg::t_evt w_evt;
    logic w_push, w_pop;

    always_comb begin
        w_evt.item = i_data;
        w_evt.pkt_ok = (i_data.pkt_len <= 7'(MAX_PACKET > 127 ? 127 : MAX_PACKET))
            && ((i_data.req_type == ubot_pkg::REQ_OUT && i_data.endpoint == 4'd2)
             || (i_data.req_type == ubot_pkg::REQ_IN && i_data.endpoint == 4'd1));
        w_evt.cbw_ok = i_data.pkt_len == ubot_pkg::CBW_LEN
            && i_data.cbw_signature == ubot_pkg::CBW_SIG;
        w_evt.bad_type = i_data.req_type > ubot_pkg::REQ_RESET;
    end

    assign o_stall = r_cnt == 2'd2;
    assign w_push = i_valid && !o_stall;
    assign o_valid = r_cnt != 2'd0;
    assign w_pop = o_valid && !i_stall;
    assign o_evt = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_evt;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ----- sv/ubot_back.sv -----
module ubot_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ubot_pkg::t_evt  i_evt,
    output logic            o_valid,
    input  logic            i_stall,
    output ubot_pkg::t_out  o_data
);
    logic [1:0]  r_mode, n_mode;
    logic [31:0] r_tag, n_tag, r_rem, n_rem, r_res, n_res, r_chunk, n_chunk;
    logic        r_fail, n_fail, r_pend, n_pend;
    logic [6:0]  r_pleft, n_pleft;
    logic        r_ovalid;
    ubot_pkg::t_out r_out, w_o;
    logic w_take;
    ubot_pkg::t_in it;

    assign it = i_evt.item;
    assign o_stall = r_ovalid && i_stall;
    assign w_take = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_comb begin
        logic [6:0]  len, n;
        logic        mv;
        w_o = '0;
        w_o.resp_code = ubot_pkg::R_STALL;
        n_mode = r_mode; n_tag = r_tag; n_rem = r_rem; n_res = r_res;
        n_chunk = r_chunk; n_fail = r_fail; n_pend = r_pend; n_pleft = r_pleft;
        len = it.pkt_len;
        mv = 1'b0;
        if (it.req_type == ubot_pkg::REQ_IN && r_mode == ubot_pkg::M_DIN
                && {25'd0, len} > r_rem)
            len = r_rem[6:0];
        // move_chunk source length
        n = (it.req_type == ubot_pkg::REQ_READY) ? r_pleft : len;
        case (it.req_type)
            ubot_pkg::REQ_OUT: begin
                if (i_evt.pkt_ok) begin
                    if (r_mode == ubot_pkg::M_CBW) begin
                        if (i_evt.cbw_ok) begin
                            n_tag = it.cbw_tag;
                            n_rem = it.cbw_transfer_len;
                            n_mode = (it.cbw_transfer_len == 32'd0) ? ubot_pkg::M_CSW :
                                     it.cbw_dir_in ? ubot_pkg::M_DIN : ubot_pkg::M_DOUT;
                            n_res = '0;
                            w_o.cmd_issue = 1'b1;
                            w_o.req_lun = it.cbw_lun;
                            if (n_mode == ubot_pkg::M_DIN) w_o.data_req = ubot_pkg::DREQ_READ;
                            else if (n_mode == ubot_pkg::M_DOUT)
                                w_o.data_req = ubot_pkg::DREQ_WRITE;
                            w_o.resp_code = ubot_pkg::R_ACC;
                            w_o.byte_count = len;
                        end
                    end else if (r_mode == ubot_pkg::M_DOUT
                            && {25'd0, len} <= r_rem) begin
                        mv = 1'b1;
                    end
                end
            end
            ubot_pkg::REQ_IN: begin
                if (i_evt.pkt_ok) begin
                    if (r_mode == ubot_pkg::M_DOUT) begin
                        if (r_rem == 32'd0 && len >= ubot_pkg::CSW_LEN) begin
                            n_pend = 1'b1;
                            w_o.resp_code = ubot_pkg::R_DEFER;
                        end
                    end else if (r_mode == ubot_pkg::M_CSW) begin
                        w_o.resp_code = ubot_pkg::R_ACC;
                        if (len >= ubot_pkg::CSW_LEN) begin
                            w_o.csw_valid = 1'b1;
                            w_o.csw_tag = r_tag;
                            w_o.csw_residue = r_res;
                            w_o.csw_status = r_fail;
                            n_mode = ubot_pkg::M_CBW;
                            w_o.byte_count = ubot_pkg::CSW_LEN;
                        end
                    end else if (r_mode == ubot_pkg::M_DIN) begin
                        mv = 1'b1;
                    end
                end
            end
            ubot_pkg::REQ_READY: begin
                w_o.resp_code = ubot_pkg::R_NONE;
                n_chunk = it.scsi_arg;
                if (r_pend) begin
                    if ({25'd0, n} > n_chunk) n = n_chunk[6:0];
                    w_o.copy_count = n;
                    n_pleft = r_pleft - n;
                    n_chunk = n_chunk - {25'd0, n};
                    n_rem = r_rem - {25'd0, n};
                    if (n_chunk == 32'd0) begin
                        if (r_mode == ubot_pkg::M_DIN) w_o.data_req = ubot_pkg::DREQ_READ;
                        else if (r_mode == ubot_pkg::M_DOUT)
                            w_o.data_req = ubot_pkg::DREQ_WRITE;
                    end
                    if (n_pleft == 7'd0) begin
                        n_pend = 1'b0;
                        w_o.resp_code = ubot_pkg::R_DONE;
                    end
                end
            end
            ubot_pkg::REQ_DONE: begin
                w_o.resp_code = ubot_pkg::R_NONE;
                n_res = r_rem;
                n_fail = it.scsi_arg != 32'd0;
                if (r_pend) begin
                    if (r_rem == 32'd0 && r_mode == ubot_pkg::M_DOUT) begin
                        // status wrapper carries the residue and status just latched
                        w_o.csw_valid = 1'b1;
                        w_o.csw_tag = r_tag;
                        w_o.csw_residue = n_res;
                        w_o.csw_status = n_fail;
                        n_mode = ubot_pkg::M_CBW;
                        w_o.byte_count = ubot_pkg::CSW_LEN;
                    end else begin
                        if (r_rem != 32'd0) begin
                            n_rem = r_rem - {25'd0, r_pleft};
                            if (r_mode == ubot_pkg::M_DIN) w_o.zero_fill_count = r_pleft;
                            n_pleft = '0;
                        end
                        if (n_rem == 32'd0) n_mode = ubot_pkg::M_CSW;
                    end
                    n_pend = 1'b0;
                    w_o.resp_code = ubot_pkg::R_DONE;
                end else if (r_rem == 32'd0) begin
                    n_mode = ubot_pkg::M_CSW;
                end
            end
            ubot_pkg::REQ_RESET: begin
                w_o.resp_code = ubot_pkg::R_NONE;
                n_mode = ubot_pkg::M_CBW;
            end
            default: ;
        endcase
        if (mv) begin
            // data_packet
            n_pleft = len;
            if (r_chunk != 32'd0) begin
                if ({25'd0, n} > r_chunk) n = r_chunk[6:0];
                w_o.copy_count = n;
                n_pleft = len - n;
                n_chunk = r_chunk - {25'd0, n};
                n_rem = r_rem - {25'd0, n};
                if (n_chunk == 32'd0) begin
                    if (r_mode == ubot_pkg::M_DIN) w_o.data_req = ubot_pkg::DREQ_READ;
                    else w_o.data_req = ubot_pkg::DREQ_WRITE;
                end
            end
            if (r_res != 32'd0 && n_pleft != 7'd0) begin
                n_rem = n_rem - {25'd0, n_pleft};
                if (it.req_type == ubot_pkg::REQ_IN) w_o.zero_fill_count = n_pleft;
                if (n_rem == 32'd0) n_mode = ubot_pkg::M_CSW;
                n_pleft = '0;
            end
            if (n_pleft != 7'd0) begin
                n_pend = 1'b1;
                w_o.resp_code = ubot_pkg::R_DEFER;
            end else begin
                w_o.resp_code = ubot_pkg::R_ACC;
                w_o.byte_count = len;
            end
        end
        w_o.mode_now = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= w_o;
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_mode <= ubot_pkg::M_CBW;
            r_tag <= '0; r_rem <= '0; r_res <= '0; r_chunk <= '0;
            r_fail <= 1'b0; r_pend <= 1'b0; r_pleft <= '0;
        end else begin
            if (w_take) begin
                r_ovalid <= 1'b1;
                r_mode <= n_mode; r_tag <= n_tag; r_rem <= n_rem; r_res <= n_res;
                r_chunk <= n_chunk; r_fail <= n_fail; r_pend <= n_pend;
                r_pleft <= n_pleft;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

// ----- sv/usb_bulk_only_transport_device.sv -----
// channel  direction  valid    stall    payload
// event    in         i_valid  o_stall  i_data (ubot_pkg::t_in)
// result   out        o_valid  i_stall  o_data (ubot_pkg::t_out)
//
// One event per cycle while o_stall is low; an accepted event's result passes through
// the front queue, then the back end's output register.
// Reset is synchronous and clears mode and all transport state.
// A two-entry queue lets the front keep taking events while the result stalls.
module usb_bulk_only_transport_device #(
    parameter int MAX_PACKET = ubot_pkg::MAX_PACKET_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ubot_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output ubot_pkg::t_out o_data
);
    logic q_valid, q_stall;
    ubot_pkg::t_evt q_evt;

    ubot_front #(.MAX_PACKET(MAX_PACKET)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(q_valid), .i_stall(q_stall), .o_evt(q_evt)
    );

    ubot_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_evt(q_evt),
        .o_valid, .i_stall, .o_data
    );
endmodule

// ----- tb/sv/ubot_checker.sv -----
module ubot_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           o_stall,
    input  ubot_pkg::t_in  i_data,
    input  logic           o_valid,
    input  logic           i_stall,
    input  ubot_pkg::t_out o_data,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  mode;
    logic [31:0] cmd_tag;
    logic [31:0] remaining_len;
    logic [31:0] residue;
    logic        cmd_failed;
    logic [31:0] chunk_left;
    logic [31:0] pkt_left;
    logic        pkt_pending;
    ubot_pkg::t_out cur;
    ubot_pkg::t_out expected_results[$];

    function automatic void request_data();
        if (mode == ubot_pkg::M_DIN) cur.data_req = ubot_pkg::DREQ_READ;
        else if (mode == ubot_pkg::M_DOUT) cur.data_req = ubot_pkg::DREQ_WRITE;
    endfunction

    function automatic void build_csw();
        cur.csw_valid = 1'b1;
        cur.csw_tag = cmd_tag;
        cur.csw_residue = residue;
        cur.csw_status = cmd_failed;
    endfunction

    function automatic void copy_chunk();
        logic [31:0] n;
        n = (pkt_left > chunk_left) ? chunk_left : pkt_left;
        cur.copy_count = cur.copy_count + n[6:0];
        pkt_left = pkt_left - n;
        chunk_left = chunk_left - n;
        remaining_len = remaining_len - n;
        if (chunk_left == 0) request_data();
    endfunction

    function automatic void take_packet(logic [31:0] len, logic is_in);
        pkt_left = len;
        if (chunk_left != 0) copy_chunk();
        if (residue != 0 && pkt_left != 0) begin
            remaining_len = remaining_len - pkt_left;
            if (is_in) cur.zero_fill_count = pkt_left[6:0];
            if (remaining_len == 0) mode = ubot_pkg::M_CSW;
            pkt_left = 0;
        end
        if (pkt_left != 0) begin
            pkt_pending = 1'b1;
            cur.resp_code = ubot_pkg::R_DEFER;
        end else begin
            cur.resp_code = ubot_pkg::R_ACC;
            cur.byte_count = len[6:0];
        end
    endfunction

    function automatic ubot_pkg::t_out predict_transport(ubot_pkg::t_in it);
        logic [31:0] len;
        len = {25'd0, it.pkt_len};
        cur = '0;
        cur.resp_code = ubot_pkg::R_STALL;
        case (it.req_type)
            ubot_pkg::REQ_OUT: begin
                if (it.endpoint == 4'd2 && len <= ubot_pkg::MAX_PACKET_DEF) begin
                    if (mode == ubot_pkg::M_CBW) begin
                        if (it.pkt_len == ubot_pkg::CBW_LEN
                                && it.cbw_signature == ubot_pkg::CBW_SIG) begin
                            cmd_tag = it.cbw_tag;
                            remaining_len = it.cbw_transfer_len;
                            if (it.cbw_transfer_len == 0) mode = ubot_pkg::M_CSW;
                            else if (it.cbw_dir_in) mode = ubot_pkg::M_DIN;
                            else mode = ubot_pkg::M_DOUT;
                            residue = '0;
                            cur.cmd_issue = 1'b1;
                            cur.req_lun = it.cbw_lun;
                            request_data();
                            cur.resp_code = ubot_pkg::R_ACC;
                            cur.byte_count = it.pkt_len;
                        end
                    end else if (mode == ubot_pkg::M_DOUT) begin
                        if (len <= remaining_len) take_packet(len, 1'b0);
                    end
                end
            end
            ubot_pkg::REQ_IN: begin
                if (it.endpoint == 4'd1 && len <= ubot_pkg::MAX_PACKET_DEF) begin
                    if (mode == ubot_pkg::M_DOUT) begin
                        if (remaining_len == 0 && it.pkt_len >= ubot_pkg::CSW_LEN) begin
                            pkt_pending = 1'b1;
                            cur.resp_code = ubot_pkg::R_DEFER;
                        end
                    end else if (mode == ubot_pkg::M_CSW) begin
                        cur.resp_code = ubot_pkg::R_ACC;
                        if (it.pkt_len >= ubot_pkg::CSW_LEN) begin
                            build_csw();
                            mode = ubot_pkg::M_CBW;
                            cur.byte_count = ubot_pkg::CSW_LEN;
                        end
                    end else if (mode == ubot_pkg::M_DIN) begin
                        if (len > remaining_len) len = remaining_len;
                        take_packet(len, 1'b1);
                    end
                end
            end
            ubot_pkg::REQ_READY: begin
                cur.resp_code = ubot_pkg::R_NONE;
                chunk_left = it.scsi_arg;
                if (pkt_pending) begin
                    copy_chunk();
                    if (pkt_left == 0) begin
                        pkt_pending = 1'b0;
                        cur.resp_code = ubot_pkg::R_DONE;
                    end
                end
            end
            ubot_pkg::REQ_DONE: begin
                cur.resp_code = ubot_pkg::R_NONE;
                residue = remaining_len;
                cmd_failed = (it.scsi_arg != 0);
                if (pkt_pending) begin
                    if (remaining_len == 0 && mode == ubot_pkg::M_DOUT) begin
                        build_csw();
                        mode = ubot_pkg::M_CBW;
                        cur.byte_count = ubot_pkg::CSW_LEN;
                    end else begin
                        if (remaining_len != 0) begin
                            remaining_len = remaining_len - pkt_left;
                            if (mode == ubot_pkg::M_DIN) cur.zero_fill_count = pkt_left[6:0];
                            pkt_left = 0;
                        end
                        if (remaining_len == 0) mode = ubot_pkg::M_CSW;
                    end
                    pkt_pending = 1'b0;
                    cur.resp_code = ubot_pkg::R_DONE;
                end else if (remaining_len == 0) begin
                    mode = ubot_pkg::M_CSW;
                end
            end
            ubot_pkg::REQ_RESET: begin
                cur.resp_code = ubot_pkg::R_NONE;
                mode = ubot_pkg::M_CBW;
            end
            default: ;
        endcase
        cur.mode_now = mode;
        return cur;
    endfunction

    always @(posedge i_clk) begin
        ubot_pkg::t_out want;
        if (!i_rst_n) begin
            mode = ubot_pkg::M_CBW;
            cmd_tag = '0;
            remaining_len = '0;
            residue = '0;
            cmd_failed = 1'b0;
            chunk_left = '0;
            pkt_left = '0;
            pkt_pending = 1'b0;
            expected_results.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_valid && !o_stall) expected_results.push_back(predict_transport(i_data));
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %p", $time, o_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want != o_data) begin
                        $display("%0t: mismatch, expected %p actual %p", $time, want, o_data);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end
endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_UNKNOWN = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    ubot_pkg::t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    ubot_pkg::t_out o_data;
    int   fail_count;
    int   pending;
    int   idle_pct = 17;
    int   hold_cycles = 0;
    int   quiet_cycles = 0;
    int   sent_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    usb_bulk_only_transport_device u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    ubot_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall, with a long forced hold-off when hold_cycles is set
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic ubot_pkg::t_in random_event();
        ubot_pkg::t_in e;
        e = '0;
        e.req_type = 3'($urandom_range(4));
        if ($urandom_range(99) < 3) e.req_type = 3'($urandom_range(7, 5));
        e.endpoint = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(2, 1));
        e.pkt_len = ($urandom_range(19) == 0) ? 7'($urandom) : 7'($urandom_range(64));
        e.cbw_signature = ($urandom_range(9) == 0) ? $urandom : ubot_pkg::CBW_SIG;
        e.cbw_tag = $urandom;
        e.cbw_transfer_len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200);
        e.cbw_dir_in = 1'($urandom);
        e.cbw_lun = 4'($urandom);
        e.scsi_arg = ($urandom_range(9) == 0) ? $urandom : $urandom_range(80);
        return e;
    endfunction

    function automatic ubot_pkg::t_in make_cbw(logic [31:0] xfer, logic dir_in);
        ubot_pkg::t_in e;
        e = random_event();
        e.req_type = ubot_pkg::REQ_OUT;
        e.endpoint = 4'd2;
        e.pkt_len = ubot_pkg::CBW_LEN;
        e.cbw_signature = ubot_pkg::CBW_SIG;
        e.cbw_transfer_len = xfer;
        e.cbw_dir_in = dir_in;
        return e;
    endfunction

    function automatic ubot_pkg::t_in make_evt(logic [2:0] kind, logic [3:0] ep,
                                               logic [6:0] len, logic [31:0] arg);
        ubot_pkg::t_in e;
        e = random_event();
        e.req_type = kind;
        e.endpoint = ep;
        e.pkt_len = len;
        e.scsi_arg = arg;
        return e;
    endfunction

    // returns at the falling edge after acceptance with valid still high
    task automatic send_event(ubot_pkg::t_in e);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data <= e;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count = sent_count + 1;
        @(negedge i_clk);
    endtask

    // a well-formed command with random content and occasional noise
    task automatic run_command();
        logic        dir_in;
        logic [31:0] xfer;
        int          n;
        dir_in = 1'($urandom);
        xfer = ($urandom_range(5) == 0) ? 32'd0 : $urandom_range(1, 160);
        send_event(make_cbw(xfer, dir_in));
        n = $urandom_range(2, 8);
        repeat (n) begin
            case ($urandom_range(9))
                0, 1, 2: send_event(make_evt(ubot_pkg::REQ_READY, 4'd0, 7'd0,
                                             $urandom_range(1, 70)));
                3, 4, 5: send_event(make_evt(dir_in ? ubot_pkg::REQ_IN : ubot_pkg::REQ_OUT,
                                             dir_in ? 4'd1 : 4'd2,
                                             7'($urandom_range(1, 64)), 32'd0));
                6: send_event(make_evt(ubot_pkg::REQ_DONE, 4'd0, 7'd0, $urandom_range(1)));
                default: send_event(random_event());
            endcase
        end
        send_event(make_evt(ubot_pkg::REQ_DONE, 4'd0, 7'd0, 32'($urandom_range(3) == 0)));
        send_event(make_evt(ubot_pkg::REQ_READY, 4'd0, 7'd0, 32'd64));
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd1, 7'($urandom_range(13, 64)), 32'd0));
    endtask

    initial begin
        ubot_pkg::t_in e;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes and special cases
        send_event(make_evt(ubot_pkg::REQ_OUT, 4'd2, 7'd127, 32'd0));     // oversized
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd3, 7'd13, 32'd0));       // wrong endpoint
        send_event(make_evt(REQ_UNKNOWN, 4'd0, 7'd0, 32'd0));             // unknown type
        send_event(make_cbw(32'd0, 1'b0));                                // zero-length command
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd1, 7'd12, 32'd0));       // short IN in CSW mode
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd1, 7'd64, 32'd0));
        send_event(make_cbw(32'hFFFF_FFFF, 1'b1));
        send_event(make_evt(ubot_pkg::REQ_READY, 4'd0, 7'd0, 32'hFFFF_FFFF));
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd1, 7'd64, 32'd0));
        send_event(make_evt(ubot_pkg::REQ_RESET, 4'd0, 7'd0, 32'd0));     // transport reset
        send_event(make_cbw(32'd100, 1'b0));
        send_event(make_evt(ubot_pkg::REQ_OUT, 4'd2, 7'd64, 32'd0));      // taken whole from the leftover chunk
        send_event(make_evt(ubot_pkg::REQ_READY, 4'd0, 7'd0, 32'd10));    // no packet pending, only sets the chunk
        send_event(make_evt(ubot_pkg::REQ_READY, 4'd0, 7'd0, 32'd60));
        send_event(make_evt(ubot_pkg::REQ_DONE, 4'd0, 7'd0, 32'hFFFF_FFFF));
        send_event(make_evt(ubot_pkg::REQ_OUT, 4'd2, 7'd36, 32'd0));      // copied whole from the chunk, no zero fill
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd1, 7'd13, 32'd0));
        send_event(make_cbw(32'd0, 1'b0));
        send_event(make_evt(ubot_pkg::REQ_DONE, 4'd0, 7'd0, 32'd0));
        send_event(make_evt(ubot_pkg::REQ_IN, 4'd1, 7'd0, 32'd0));
        e = make_cbw(32'd5, 1'b0); e.cbw_signature = 32'h0; send_event(e);
        e = make_evt(ubot_pkg::REQ_READY, 4'hF, 7'h7F, 32'd0); e.cbw_lun = 4'hF; send_event(e);

        // pause until drained
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        // receiver hold-off while offering items
        hold_cycles = 60;
        repeat (12) send_event(random_event());

        while (sent_count < 1100) begin
            if (sent_count > 400 && sent_count < 600) idle_pct = 0;
            else idle_pct = 17;
            if ($urandom_range(9) < 7) run_command();
            else send_event(random_event());
        end
        i_valid <= 1'b0;
        idle_pct = 17;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
